// ===== hdl/ctmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular tile minimap - shared definitions
// Tile classes, pixel kinds, operation codes and the map character decoder.
// ----------------------------------------------------------------------------
package ctmm_pkg;

    typedef logic [1:0] t_class;
    typedef logic [1:0] t_kind;

    localparam t_class CLASS_EMPTY = 2'd0;
    localparam t_class CLASS_FLOOR = 2'd1;
    localparam t_class CLASS_WALL  = 2'd2;

    localparam t_kind KIND_RING   = 2'd0;
    localparam t_kind KIND_PLAYER = 2'd1;
    localparam t_kind KIND_EMPTY  = 2'd2;
    localparam t_kind KIND_TILE   = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [7:0] CHAR_WALL  = 8'h31;
    localparam logic [7:0] CHAR_FLOOR = 8'h30;
    localparam logic [7:0] CHAR_NORTH = 8'h4E;
    localparam logic [7:0] CHAR_SOUTH = 8'h53;
    localparam logic [7:0] CHAR_EAST  = 8'h45;
    localparam logic [7:0] CHAR_WEST  = 8'h57;

    localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;

    function automatic t_class classify(input logic [7:0] ch);
        t_class cls;
        begin
            if (ch == CHAR_WALL) begin
                cls = CLASS_WALL;
            end else if (ch inside {CHAR_FLOOR, CHAR_NORTH, CHAR_SOUTH, CHAR_EAST,
                                    CHAR_WEST}) begin
                cls = CLASS_FLOOR;
            end else begin
                cls = CLASS_EMPTY;
            end
            return cls;
        end
    endfunction

endpackage

// ===== hdl/ctmm_locate.sv =====
// ----------------------------------------------------------------------------
// Circular tile minimap - pixel locator
// Classifies a pixel against the ring, the player dot and the disc, and maps
// it onto a tile address with a bounds check.
// ----------------------------------------------------------------------------
module ctmm_locate
    import ctmm_pkg::*;
#(
    parameter int MAP_SIDE        = 64,
    parameter int VIEW_RADIUS     = 60,
    parameter int PIXELS_PER_TILE = 25,
    parameter int SIDE_W          = 6
) (
    input  logic [6:0]          i_pixel_x,
    input  logic [6:0]          i_pixel_y,
    input  logic [10:0]         i_player_x_25,
    input  logic [10:0]         i_player_y_25,
    input  logic [6:0]          i_map_width,
    input  logic [6:0]          i_map_height,
    output t_kind               o_kind,
    output logic [2*SIDE_W-1:0] o_addr
);

    localparam int DX_W    = 10;
    localparam int ADX_W   = 9;
    localparam int D2_W    = 2 * ADX_W + 1;
    localparam int POS_W   = 13;
    localparam int MAG_W   = POS_W - 1;
    localparam int SHIFT   = MAG_W + $clog2(PIXELS_PER_TILE);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(PIXELS_PER_TILE) - 64'd1) / 64'(PIXELS_PER_TILE));
    localparam logic [D2_W-1:0] OUTER2 = D2_W'(VIEW_RADIUS * VIEW_RADIUS);
    localparam logic [D2_W-1:0] INNER2 = D2_W'((VIEW_RADIUS - 1) * (VIEW_RADIUS - 1));
    localparam logic [D2_W-1:0] DOT2   = D2_W'(4);
    localparam logic [MAG_W-1:0] SIDE_LIM = MAG_W'(MAP_SIDE);

    function automatic logic [MAG_W:0] to_tile(input logic signed [POS_W-1:0] pos);
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        begin
            mag  = pos[POS_W-1] ? MAG_W'(-pos) : MAG_W'(pos);
            prod = PROD_W'(mag) * PROD_W'(RECIP);
            return {pos[POS_W-1], prod[SHIFT +: MAG_W]};
        end
    endfunction

    logic signed [DX_W-1:0]  dx;
    logic signed [DX_W-1:0]  dy;
    logic [ADX_W-1:0]        adx;
    logic [ADX_W-1:0]        ady;
    logic [D2_W-1:0]         d2;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [MAG_W:0]          tile_x;
    logic [MAG_W:0]          tile_y;
    logic                    oob_x;
    logic                    oob_y;

    assign dx = $signed({{(DX_W-7){1'b0}}, i_pixel_x}) - $signed(DX_W'(VIEW_RADIUS));
    assign dy = $signed({{(DX_W-7){1'b0}}, i_pixel_y}) - $signed(DX_W'(VIEW_RADIUS));

    assign adx = dx[DX_W-1] ? ADX_W'(-dx) : ADX_W'(dx);
    assign ady = dy[DX_W-1] ? ADX_W'(-dy) : ADX_W'(dy);
    assign d2  = D2_W'(adx) * D2_W'(adx) + D2_W'(ady) * D2_W'(ady);

    assign pos_x = $signed({{(POS_W-11){1'b0}}, i_player_x_25}) + POS_W'(dx);
    assign pos_y = $signed({{(POS_W-11){1'b0}}, i_player_y_25}) + POS_W'(dy);

    assign tile_x = to_tile(pos_x);
    assign tile_y = to_tile(pos_y);

    assign oob_x = (tile_x[MAG_W] && (tile_x[MAG_W-1:0] != '0))
                || (tile_x[MAG_W-1:0] >= MAG_W'(i_map_width))
                || (tile_x[MAG_W-1:0] >= SIDE_LIM);
    assign oob_y = (tile_y[MAG_W] && (tile_y[MAG_W-1:0] != '0))
                || (tile_y[MAG_W-1:0] >= MAG_W'(i_map_height))
                || (tile_y[MAG_W-1:0] >= SIDE_LIM);

    assign o_addr = {SIDE_W'(tile_y[MAG_W-1:0]), SIDE_W'(tile_x[MAG_W-1:0])};

    always_comb begin
        if (d2 >= INNER2 && d2 <= OUTER2) begin
            o_kind = KIND_RING;
        end else if (d2 <= DOT2) begin
            o_kind = KIND_PLAYER;
        end else if (d2 > OUTER2 || oob_x || oob_y) begin
            o_kind = KIND_EMPTY;
        end else begin
            o_kind = KIND_TILE;
        end
    end

endmodule

// ===== hdl/circular_tile_minimap_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// Circular tile minimap pixel unit
// Tile store loaded by write words; pixel words return one minimap colour.
// ----------------------------------------------------------------------------
// Takes one input word per clock while o_in_ready is high; it is low during
// the clear sweep and while a stalled output holds the input register. The
// input register feeds the pixel locator (one reciprocal multiply per axis)
// and a registered read of the single-port tile store, and the store read
// register with the region code forms the output stage that presents a pixel
// word's colour. Tile writes retire through the same port and give no output
// word. After reset the tile store is swept clear, one entry per clock, over
// all 2**(2*SIDE_W) entries (4096 with MAP_SIDE of 64); o_in_ready stays low
// during the sweep, while the register port works as normal.
module circular_tile_minimap_pixel_unit
    import ctmm_pkg::*;
#(
    parameter int MAP_SIDE        = 64,
    parameter int VIEW_RADIUS     = 60,
    parameter int PIXELS_PER_TILE = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [6:0]  i_pixel_x,
    input  logic [6:0]  i_pixel_y,
    input  logic [5:0]  i_tile_col,
    input  logic [5:0]  i_tile_row,
    input  logic [7:0]  i_tile_char,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_pixel_color
);

    localparam int SIDE_W = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
    localparam int ADDR_W = 2 * SIDE_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [2:0] REG_MAP_WIDTH    = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_PLAYER_X     = 3'd2;
    localparam logic [2:0] REG_PLAYER_Y     = 3'd3;
    localparam logic [2:0] REG_COLOR_EMPTY  = 3'd4;
    localparam logic [2:0] REG_COLOR_WALL   = 3'd5;
    localparam logic [2:0] REG_COLOR_FLOOR  = 3'd6;
    localparam logic [2:0] REG_COLOR_PLAYER = 3'd7;

    logic [6:0]  r_map_width;
    logic [6:0]  r_map_height;
    logic [10:0] r_player_x_25;
    logic [10:0] r_player_y_25;
    logic [23:0] r_color_empty;
    logic [23:0] r_color_wall;
    logic [23:0] r_color_floor;
    logic [23:0] r_color_player;

    logic        r_s1_valid;
    logic        r_s1_opcode;
    logic [6:0]  r_s1_pixel_x;
    logic [6:0]  r_s1_pixel_y;
    logic [5:0]  r_s1_tile_col;
    logic [5:0]  r_s1_tile_row;
    logic [7:0]  r_s1_tile_char;

    logic        r_s2_valid;
    t_kind       r_s2_kind;
    t_class      r_rd_class;

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    t_class            r_tile_mem [DEPTH];

    logic              cfg_wr;
    logic [2:0]        cfg_idx;
    logic              advance;
    logic              in_accept;
    logic              mem_wr;
    logic              mem_rd;
    logic              wr_in_range;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    t_kind             s1_kind;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width    <= '0;
            r_map_height   <= '0;
            r_player_x_25  <= '0;
            r_player_y_25  <= '0;
            r_color_empty  <= '0;
            r_color_wall   <= '0;
            r_color_floor  <= '0;
            r_color_player <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MAP_WIDTH:    r_map_width    <= pwdata[6:0];
                REG_MAP_HEIGHT:   r_map_height   <= pwdata[6:0];
                REG_PLAYER_X:     r_player_x_25  <= pwdata[10:0];
                REG_PLAYER_Y:     r_player_y_25  <= pwdata[10:0];
                REG_COLOR_EMPTY:  r_color_empty  <= pwdata[23:0];
                REG_COLOR_WALL:   r_color_wall   <= pwdata[23:0];
                REG_COLOR_FLOOR:  r_color_floor  <= pwdata[23:0];
                REG_COLOR_PLAYER: r_color_player <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MAP_WIDTH:    prdata = 32'(r_map_width);
            REG_MAP_HEIGHT:   prdata = 32'(r_map_height);
            REG_PLAYER_X:     prdata = 32'(r_player_x_25);
            REG_PLAYER_Y:     prdata = 32'(r_player_y_25);
            REG_COLOR_EMPTY:  prdata = 32'(r_color_empty);
            REG_COLOR_WALL:   prdata = 32'(r_color_wall);
            REG_COLOR_FLOOR:  prdata = 32'(r_color_floor);
            REG_COLOR_PLAYER: prdata = 32'(r_color_player);
            default:          prdata = '0;
        endcase
    end

    assign advance    = !r_s2_valid || i_out_ready;
    assign o_in_ready = !r_clearing && (!r_s1_valid || advance);
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_opcode    <= i_opcode;
            r_s1_pixel_x   <= i_pixel_x;
            r_s1_pixel_y   <= i_pixel_y;
            r_s1_tile_col  <= i_tile_col;
            r_s1_tile_row  <= i_tile_row;
            r_s1_tile_char <= i_tile_char;
        end
    end

    ctmm_locate #(
        .MAP_SIDE        (MAP_SIDE),
        .VIEW_RADIUS     (VIEW_RADIUS),
        .PIXELS_PER_TILE (PIXELS_PER_TILE),
        .SIDE_W          (SIDE_W)
    ) u_locate (
        .i_pixel_x     (r_s1_pixel_x),
        .i_pixel_y     (r_s1_pixel_y),
        .i_player_x_25 (r_player_x_25),
        .i_player_y_25 (r_player_y_25),
        .i_map_width   (r_map_width),
        .i_map_height  (r_map_height),
        .o_kind        (s1_kind),
        .o_addr        (rd_addr)
    );

    assign wr_in_range = (9'(r_s1_tile_col) < 9'(MAP_SIDE))
                      && (9'(r_s1_tile_row) < 9'(MAP_SIDE));
    assign wr_addr = {SIDE_W'(r_s1_tile_row), SIDE_W'(r_s1_tile_col)};
    assign mem_wr  = r_s1_valid && advance && (r_s1_opcode == OP_WRITE) && wr_in_range;
    assign mem_rd  = r_s1_valid && advance && (r_s1_opcode == OP_PIXEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_tile_mem[r_clr_addr] <= CLASS_EMPTY;
        end else if (mem_wr) begin
            r_tile_mem[wr_addr] <= classify(r_s1_tile_char);
        end
        if (mem_rd) begin
            r_rd_class <= r_tile_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid && (r_s1_opcode == OP_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_kind <= s1_kind;
        end
    end

    assign o_out_valid = r_s2_valid;

    always_comb begin
        case (r_s2_kind)
            KIND_RING:   o_pixel_color = COLOR_WHITE;
            KIND_PLAYER: o_pixel_color = r_color_player;
            KIND_EMPTY:  o_pixel_color = r_color_empty;
            KIND_TILE: begin
                case (r_rd_class)
                    CLASS_WALL:  o_pixel_color = r_color_wall;
                    CLASS_FLOOR: o_pixel_color = r_color_floor;
                    default:     o_pixel_color = r_color_empty;
                endcase
            end
            default:     o_pixel_color = r_color_empty;
        endcase
    end

endmodule

// ===== test/ctmm_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular tile minimap - pixel checker
// Follows the register port and both word channels, keeps its own tile map
// and register copies, predicts the colour of every accepted pixel word and
// compares it with the oldest prediction when the result word is accepted.
// ----------------------------------------------------------------------------
package ctmm_tb_pkg;

    typedef enum logic [2:0] {
        REG_MAP_WIDTH,
        REG_MAP_HEIGHT,
        REG_PLAYER_X,
        REG_PLAYER_Y,
        REG_COLOR_EMPTY,
        REG_COLOR_WALL,
        REG_COLOR_FLOOR,
        REG_COLOR_PLAYER
    } t_reg;

endpackage

module ctmm_pixel_checker
    import ctmm_pkg::*;
    import ctmm_tb_pkg::*;
#(
    parameter int MAP_SIDE        = 64,
    parameter int VIEW_RADIUS     = 60,
    parameter int PIXELS_PER_TILE = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_opcode,
    input  logic [6:0]  i_pixel_x,
    input  logic [6:0]  i_pixel_y,
    input  logic [5:0]  i_tile_col,
    input  logic [5:0]  i_tile_row,
    input  logic [7:0]  i_tile_char,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_pixel_color,
    output int          o_mismatches,
    output int          o_pending
);

    localparam int DISC_R2  = VIEW_RADIUS * VIEW_RADIUS;
    localparam int RING_IN2 = (VIEW_RADIUS - 1) * (VIEW_RADIUS - 1);
    localparam int DOT_R2   = 4;

    t_class      tile_map [MAP_SIDE * MAP_SIDE];
    logic [6:0]  map_w;
    logic [6:0]  map_h;
    logic [10:0] pos_x;
    logic [10:0] pos_y;
    logic [23:0] rgb_empty;
    logic [23:0] rgb_wall;
    logic [23:0] rgb_floor;
    logic [23:0] rgb_player;
    logic [23:0] colour_q [$];

    initial o_mismatches = 0;
    initial o_pending = 0;

    function automatic t_class char_class(input logic [7:0] ch);
        case (ch)
            CHAR_WALL: return CLASS_WALL;
            CHAR_FLOOR, CHAR_NORTH, CHAR_SOUTH, CHAR_EAST, CHAR_WEST: return CLASS_FLOOR;
            default: return CLASS_EMPTY;
        endcase
    endfunction

    function automatic logic [23:0] pixel_colour(input logic [6:0] px, input logic [6:0] py);
        int dx;
        int dy;
        int d2;
        int tx;
        int ty;
        dx = int'(px) - VIEW_RADIUS;
        dy = int'(py) - VIEW_RADIUS;
        d2 = dx * dx + dy * dy;
        if (d2 >= RING_IN2 && d2 <= DISC_R2) begin
            return COLOR_WHITE;
        end
        if (d2 <= DOT_R2) begin
            return rgb_player;
        end
        if (d2 > DISC_R2) begin
            return rgb_empty;
        end
        // integer division truncates toward zero, as the tile lookup needs
        tx = (int'(pos_x) + dx) / PIXELS_PER_TILE;
        ty = (int'(pos_y) + dy) / PIXELS_PER_TILE;
        if (tx < 0 || ty < 0 || tx >= int'(map_w) || ty >= int'(map_h)
            || tx >= MAP_SIDE || ty >= MAP_SIDE) begin
            return rgb_empty;
        end
        case (tile_map[ty * MAP_SIDE + tx])
            CLASS_WALL: return rgb_wall;
            CLASS_FLOOR: return rgb_floor;
            default: return rgb_empty;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (tile_map[i]) tile_map[i] = CLASS_EMPTY;
            map_w      = '0;
            map_h      = '0;
            pos_x      = '0;
            pos_y      = '0;
            rgb_empty  = '0;
            rgb_wall   = '0;
            rgb_floor  = '0;
            rgb_player = '0;
            colour_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg'(paddr[4:2]))
                    REG_MAP_WIDTH:    map_w      = pwdata[6:0];
                    REG_MAP_HEIGHT:   map_h      = pwdata[6:0];
                    REG_PLAYER_X:     pos_x      = pwdata[10:0];
                    REG_PLAYER_Y:     pos_y      = pwdata[10:0];
                    REG_COLOR_EMPTY:  rgb_empty  = pwdata[23:0];
                    REG_COLOR_WALL:   rgb_wall   = pwdata[23:0];
                    REG_COLOR_FLOOR:  rgb_floor  = pwdata[23:0];
                    REG_COLOR_PLAYER: rgb_player = pwdata[23:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_opcode == OP_WRITE) begin
                    if (int'(i_tile_col) < MAP_SIDE && int'(i_tile_row) < MAP_SIDE) begin
                        tile_map[int'(i_tile_row) * MAP_SIDE + int'(i_tile_col)] =
                            char_class(i_tile_char);
                    end
                end else begin
                    colour_q.push_back(pixel_colour(i_pixel_x, i_pixel_y));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (colour_q.size() == 0) begin
                    $error("pixel_color: expected none, actual %06h", i_pixel_color);
                    o_mismatches++;
                end else if (colour_q[0] !== i_pixel_color) begin
                    $error("pixel_color: expected %06h, actual %06h", colour_q[0],
                           i_pixel_color);
                    o_mismatches++;
                    void'(colour_q.pop_front());
                end else begin
                    void'(colour_q.pop_front());
                end
            end
        end
        o_pending <= colour_q.size();
    end

endmodule

// ===== test/tb_circular_tile_minimap_pixel_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular tile minimap pixel unit - testbench
// Loads tile maps and register settings, then streams directed and random
// tile and pixel words with bursty input and a stalling output; the checker
// beside the unit predicts and compares every colour word.
// ----------------------------------------------------------------------------
module tb_circular_tile_minimap_pixel_unit;
    import ctmm_pkg::*;
    import ctmm_tb_pkg::*;

    localparam int MAP_SIDE        = 64;
    localparam int VIEW_RADIUS     = 60;
    localparam int PIXELS_PER_TILE = 25;
    localparam int POS_MAX         = 1600;
    localparam int QUIET_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 140;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_opcode    = OP_WRITE;
    logic [6:0]  i_pixel_x   = '0;
    logic [6:0]  i_pixel_y   = '0;
    logic [5:0]  i_tile_col  = '0;
    logic [5:0]  i_tile_row  = '0;
    logic [7:0]  i_tile_char = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [23:0] o_pixel_color;

    int mismatches;
    int pending;
    int burst_left   = 0;
    bit steady       = 1'b0;
    int holds_asked  = 0;
    int holds_served = 0;
    int cur_w        = 0;
    int cur_px       = 0;
    int cur_py       = 0;

    circular_tile_minimap_pixel_unit #(
        .MAP_SIDE        (MAP_SIDE),
        .VIEW_RADIUS     (VIEW_RADIUS),
        .PIXELS_PER_TILE (PIXELS_PER_TILE)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_tile_col    (i_tile_col),
        .i_tile_row    (i_tile_row),
        .i_tile_char   (i_tile_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_color (o_pixel_color)
    );

    ctmm_pixel_checker #(
        .MAP_SIDE        (MAP_SIDE),
        .VIEW_RADIUS     (VIEW_RADIUS),
        .PIXELS_PER_TILE (PIXELS_PER_TILE)
    ) u_pixel_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_tile_col    (i_tile_col),
        .i_tile_row    (i_tile_row),
        .i_tile_char   (i_tile_char),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_pixel_color (o_pixel_color),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic reg_write(input t_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic op, input logic [6:0] px, input logic [6:0] py,
                             input logic [5:0] col, input logic [5:0] row,
                             input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_pixel_x   <= px;
        i_pixel_y   <= py;
        i_tile_col  <= col;
        i_tile_row  <= row;
        i_tile_char <= ch;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic put_tile(input int col, input int row, input logic [7:0] ch);
        send_word(OP_WRITE, 7'($urandom), 7'($urandom), 6'(col), 6'(row), ch);
    endtask

    task automatic ask_pixel(input int px, input int py);
        send_word(OP_PIXEL, 7'(px), 7'(py), 6'($urandom), 6'($urandom), 8'($urandom));
    endtask

    // hold until every colour word has come back and writes have retired
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0: return CHAR_WALL;
            1: return CHAR_FLOOR;
            2: return CHAR_NORTH;
            3: return CHAR_SOUTH;
            4: return CHAR_EAST;
            5: return CHAR_WEST;
            6: return CHAR_WALL;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int near_tile(input int pos);
        int t;
        t = pos / PIXELS_PER_TILE + int'($urandom_range(0, 6)) - 3;
        if (t < 0) begin
            t = 0;
        end else if (t > MAP_SIDE - 1) begin
            t = MAP_SIDE - 1;
        end
        return t;
    endfunction

    function automatic logic [23:0] pick_colour(input int ph, input bit bright);
        if (ph == 1) begin
            return bright ? COLOR_WHITE : 24'h000000;
        end
        return 24'($urandom);
    endfunction

    task automatic configure(input int ph);
        int h;
        cur_w  = (ph == 1) ? 0 : (ph % 2 == 0) ? MAP_SIDE : $urandom_range(1, MAP_SIDE);
        h      = (ph == 5) ? 0 : (ph % 3 == 0) ? MAP_SIDE : $urandom_range(1, MAP_SIDE);
        cur_px = (ph == 0) ? 0 : (ph == 2) ? POS_MAX
                 : $urandom_range(0, (cur_w > 0 ? cur_w : 1) * PIXELS_PER_TILE);
        cur_py = (ph == 0) ? POS_MAX : (ph == 4) ? 0 : $urandom_range(0, POS_MAX);
        reg_write(REG_MAP_WIDTH, cur_w);
        reg_write(REG_MAP_HEIGHT, h);
        reg_write(REG_PLAYER_X, cur_px);
        reg_write(REG_PLAYER_Y, cur_py);
        reg_write(REG_COLOR_EMPTY, 32'(pick_colour(ph, 1'b0)));
        reg_write(REG_COLOR_WALL, 32'(pick_colour(ph, 1'b1)));
        reg_write(REG_COLOR_FLOOR, 32'(pick_colour(ph, 1'b1)));
        reg_write(REG_COLOR_PLAYER, 32'(pick_colour(ph, 1'b0)));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full map, player at the top left corner, distinct colours
        reg_write(REG_MAP_WIDTH, MAP_SIDE);
        reg_write(REG_MAP_HEIGHT, MAP_SIDE);
        reg_write(REG_PLAYER_X, 0);
        reg_write(REG_PLAYER_Y, 0);
        reg_write(REG_COLOR_EMPTY, 32'h00102030);
        reg_write(REG_COLOR_WALL, 32'h00A05010);
        reg_write(REG_COLOR_FLOOR, 32'h0030C040);
        reg_write(REG_COLOR_PLAYER, 32'h00E01090);

        put_tile(0, 0, CHAR_WALL);
        put_tile(1, 0, CHAR_NORTH);
        put_tile(0, 1, CHAR_SOUTH);
        put_tile(1, 1, CHAR_FLOOR);
        put_tile(1, 2, CHAR_WEST);
        put_tile(63, 63, CHAR_EAST);
        put_tile(2, 0, 8'hFF);
        put_tile(0, 2, 8'h00);
        ask_pixel(60, 60);
        ask_pixel(62, 60);
        ask_pixel(63, 60);
        ask_pixel(0, 60);
        ask_pixel(1, 60);
        ask_pixel(2, 60);
        ask_pixel(40, 60);
        ask_pixel(85, 60);
        ask_pixel(60, 85);
        ask_pixel(110, 60);
        ask_pixel(85, 85);
        ask_pixel(85, 110);
        ask_pixel(0, 0);
        ask_pixel(127, 127);
        ask_pixel(119, 0);

        // player at the far corner: the last tile and beyond the store
        drain();
        reg_write(REG_PLAYER_X, POS_MAX);
        reg_write(REG_PLAYER_Y, POS_MAX);
        ask_pixel(35, 35);
        ask_pixel(85, 85);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            configure(ph);
            steady = (ph == 3);
            if (ph == 2 || ph == 4) begin
                holds_asked++;
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n < WORDS_PER_PHASE / 4 || $urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        put_tile($urandom_range(0, MAP_SIDE - 1),
                                 $urandom_range(0, MAP_SIDE - 1), 8'($urandom));
                    end else begin
                        put_tile(near_tile(cur_px), near_tile(cur_py), pick_char());
                    end
                end else if ($urandom_range(0, 19) == 0) begin
                    ask_pixel($urandom_range(0, 127), $urandom_range(0, 127));
                end else begin
                    ask_pixel($urandom_range(0, 119), $urandom_range(0, 119));
                end
            end
        end

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("tb_circular_tile_minimap_pixel_unit passed");
        end else begin
            $display("tb_circular_tile_minimap_pixel_unit failed");
        end
        $finish;
    end

    initial begin
        int span;
        t_rx_mode mode;
        forever begin
            @(posedge i_clk);
            if (holds_served < holds_asked) begin
                holds_served++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(10, 200);
            repeat (span) begin
                if (holds_served < holds_asked) begin
                    break;
                end
                case (mode)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_COIN:   i_out_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: i_out_ready <= ($urandom_range(0, 5) == 0);
                    default:   i_out_ready <= ~i_out_ready;
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_circular_tile_minimap_pixel_unit failed");
        $finish;
    end

endmodule

// ===== circular_tile_minimap_pixel_unit.f =====
hdl/ctmm_pkg.sv
hdl/ctmm_locate.sv
hdl/circular_tile_minimap_pixel_unit.sv
test/ctmm_pixel_checker.sv
test/tb_circular_tile_minimap_pixel_unit.sv
